// ===== hdl/hrlp_pkg.sv =====
// Shared types, codes and constants for the HTTP request-line parser.
`timescale 1ns / 1ps
package hrlp_pkg;

  localparam logic [6:0] METHOD_LIMIT = 7'd64;
  localparam logic [8:0] PATH_LIMIT   = 9'd256;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_VARIANT = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_DELIM    = 3'd1;
  localparam logic [2:0] ST_METHOD_LONG = 3'd2;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;

  // method names, first character in the low byte
  localparam logic [63:0] NAME_TAB [8] = '{
    {40'd0, "TEG"},
    {32'd0, "TSOP"},
    {40'd0, "TUP"},
    {32'd0, "DAEH"},
    {8'd0,  "TCENNOC"},
    {16'd0, "ETELED"},
    {8'd0,  "SNOITPO"},
    {24'd0, "HCTAP"}
  };
  localparam logic [6:0] NAME_LEN [8] = '{7'd3, 7'd4, 7'd3, 7'd4, 7'd7, 7'd6, 7'd7, 7'd5};

  typedef enum logic [4:0] {
    PH_METHOD  = 5'b00001,
    PH_PATH    = 5'b00010,
    PH_VARIANT = 5'b00100,
    PH_VERSION = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [2:0] method;
    logic [6:0] version_major;
    logic [6:0] version_minor;
  } res_t;

endpackage

// ===== hdl/hrlp_in_reg.sv =====
// Input register stage of the request-line parser.
`timescale 1ns / 1ps
module hrlp_in_reg
  import hrlp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  beat_t in_beat,
  output logic  in_ready,
  input  logic  down_ready,
  output logic  s1_valid,
  output beat_t s1_beat
);

  logic  s1_valid_r;
  beat_t s1_beat_r;

  assign in_ready = !s1_valid_r || down_ready;
  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_beat_r <= in_beat;
    end
  end

endmodule

// ===== hdl/hrlp_core.sv =====
// Parser state and per-byte next-state and result logic.
`timescale 1ns / 1ps
module hrlp_core
  import hrlp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  beat_t beat,
  output res_t  res
);

  phase_t          phase_r, phase_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [6:0]      mlen_r, mlen_nxt;
  logic [8:0]      plen_r, plen_nxt;
  logic            over_r, over_nxt;
  logic [2:0][7:0] vch_r, vch_nxt;
  logic [1:0]      vcnt_r, vcnt_nxt;
  logic            crp_r, crp_nxt;
  logic            hit;
  logic [2:0]      hit_idx;
  logic [7:0]      b;
  logic [7:0]      flags_cur;
  logic [6:0]      mlen_cur;

  assign b = beat.data_byte;

  // match state as seen by this beat, after a restart if it carries one
  assign flags_cur = beat.restart ? 8'hFF : flags_r;
  assign mlen_cur  = beat.restart ? 7'd0 : mlen_r;

  // first surviving name whose length matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (flags_cur[i] && (mlen_cur == NAME_LEN[i])) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  function automatic res_t verdict(input logic [2:0][7:0] vc, input logic [2:0] meth);
    res_t r;
    logic ok;
    r          = '0;
    r.kind     = KIND_VERDICT;
    ok         = (vc[0] >= CH_ZERO) && !vc[0][7];
    r.version_major = 7'(vc[0] - CH_ZERO);
    if (vc[1] == CH_DOT) begin
      if ((vc[2] >= CH_ZERO) && !vc[2][7]) begin
        r.version_minor = 7'(vc[2] - CH_ZERO);
      end else begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      r.status = ST_OK;
      r.method = meth;
    end else begin
      r        = '0;
      r.kind   = KIND_VERDICT;
      r.status = ST_BAD_VERSION;
    end
    return r;
  endfunction

  always_comb begin
    logic go;
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    mlen_nxt  = mlen_r;
    plen_nxt  = plen_r;
    over_nxt  = over_r;
    vch_nxt   = vch_r;
    vcnt_nxt  = vcnt_r;
    crp_nxt   = crp_r;
    go        = 1'b1;
    res       = '0;
    if (beat.restart) begin
      phase_nxt = PH_METHOD;
      flags_nxt = 8'hFF;
      mlen_nxt  = '0;
      plen_nxt  = '0;
      over_nxt  = 1'b0;
      vch_nxt   = '0;
      vcnt_nxt  = '0;
      crp_nxt   = 1'b0;
    end
    case (phase_nxt)
      PH_METHOD: begin
        if (b == CH_NUL) begin
          phase_nxt  = PH_DONE;
          res.kind   = KIND_VERDICT;
          res.status = ST_NO_DELIM;
        end else if (b == CH_SPACE) begin
          if (mlen_nxt >= METHOD_LIMIT) begin
            phase_nxt  = PH_DONE;
            res.kind   = KIND_VERDICT;
            res.status = ST_METHOD_LONG;
          end else if (!hit) begin
            phase_nxt  = PH_DONE;
            res.kind   = KIND_VERDICT;
            res.status = ST_BAD_METHOD;
          end else begin
            phase_nxt = PH_PATH;
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (!((mlen_nxt < 7'd8) &&
                  (NAME_TAB[i][{mlen_nxt[2:0], 3'b000} +: 8] == b))) begin
              flags_nxt[i] = 1'b0;
            end
          end
          if (mlen_nxt != 7'd127) begin
            mlen_nxt = mlen_nxt + 7'd1;
          end
        end
      end
      PH_PATH: begin
        if (b == CH_NUL) begin
          phase_nxt  = PH_DONE;
          res.kind   = KIND_VERDICT;
          res.status = ST_NO_DELIM;
        end else if (b == CH_SPACE) begin
          if (over_nxt) begin
            phase_nxt  = PH_DONE;
            res.kind   = KIND_VERDICT;
            res.status = ST_BAD_METHOD;
          end else begin
            phase_nxt = PH_VARIANT;
          end
        end else begin
          if (plen_nxt != 9'd511) begin
            plen_nxt = plen_nxt + 9'd1;
          end
          if (plen_nxt >= PATH_LIMIT) begin
            over_nxt = 1'b1;
          end
          res.kind      = KIND_PATH;
          res.data_byte = b;
        end
      end
      PH_VARIANT: begin
        if (b == CH_NUL) begin
          phase_nxt  = PH_DONE;
          res.kind   = KIND_VERDICT;
          res.status = ST_NO_DELIM;
        end else if (b == CH_SLASH) begin
          phase_nxt = PH_VERSION;
        end else begin
          res.kind      = KIND_VARIANT;
          res.data_byte = b;
        end
      end
      PH_VERSION: begin
        if (crp_nxt) begin
          crp_nxt = 1'b0;
          if (b == CH_LF) begin
            phase_nxt = PH_DONE;
            res       = verdict(vch_nxt, hit_idx);
            go        = 1'b0;
          end else if (vcnt_nxt != 2'd3) begin
            // lone CR counts as a version character
            vch_nxt[vcnt_nxt] = CH_CR;
            vcnt_nxt = vcnt_nxt + 2'd1;
          end
        end
        if (go) begin
          if (b == CH_NUL) begin
            phase_nxt  = PH_DONE;
            res.kind   = KIND_VERDICT;
            res.status = ST_BAD_VERSION;
          end else if (b == CH_SPACE) begin
            phase_nxt = PH_DONE;
            res       = verdict(vch_nxt, hit_idx);
          end else if (b == CH_CR) begin
            crp_nxt = 1'b1;
          end else if (vcnt_nxt != 2'd3) begin
            vch_nxt[vcnt_nxt] = b;
            vcnt_nxt = vcnt_nxt + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      flags_r <= 8'hFF;
      mlen_r  <= '0;
      plen_r  <= '0;
      over_r  <= 1'b0;
      vch_r   <= '0;
      vcnt_r  <= '0;
      crp_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      mlen_r  <= mlen_nxt;
      plen_r  <= plen_nxt;
      over_r  <= over_nxt;
      vch_r   <= vch_nxt;
      vcnt_r  <= vcnt_nxt;
      crp_r   <= crp_nxt;
    end
  end

endmodule

// ===== hdl/hrlp_out_reg.sv =====
// Result register stage of the request-line parser.
`timescale 1ns / 1ps
module hrlp_out_reg
  import hrlp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s1_valid,
  input  res_t res,
  output logic up_ready,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic out_valid_r;
  res_t out_res_r;

  assign up_ready  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && s1_valid) begin
      out_res_r <= res;
    end
  end

endmodule

// ===== hdl/http_request_line_parser_unit.sv =====
// Path: a beat accepted into the input register passes the core logic and is
// captured in the result register, which drives the result ports. Throughput:
// one byte per cycle while out_stall is low; the phase update and name
// compares fit in the single stage between the input and result registers.
// Exactly one result beat per input beat (kind none when nothing to report).
// Reset (synchronous, rst_n low) empties both stages and returns the parser
// to the method phase with all names still matching.
`timescale 1ns / 1ps
module http_request_line_parser_unit
  import hrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic [2:0] out_method,
  output logic [6:0] out_version_major,
  output logic [6:0] out_version_minor
);

  beat_t in_beat, s1_beat;
  logic  in_ready, s1_valid, down_ready;
  res_t  res, out_res;

  assign in_beat.data_byte = in_data_byte;
  assign in_beat.restart   = in_restart;
  assign in_stall          = !in_ready;

  hrlp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_beat    (in_beat),
    .in_ready   (in_ready),
    .down_ready (down_ready),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat)
  );

  hrlp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_valid && down_ready),
    .beat  (s1_beat),
    .res   (res)
  );

  hrlp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .up_ready  (down_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_byte          = out_res.data_byte;
  assign out_status        = out_res.status;
  assign out_method        = out_res.method;
  assign out_version_major = out_res.version_major;
  assign out_version_minor = out_res.version_minor;

endmodule
